// ===== rtl/ngi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngi_pkg
// Types, sizes and the sequencer program of the next-greater-index block.
// ----------------------------------------------------------------------------
package ngi_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int KEY_W      = VALUE_BITS;

  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic [5:0] position;
    logic [5:0] next_index;
    logic       has_greater;
    logic       overflowed;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } stack_entry_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } answer_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_FETCH,
    S_GETV,
    S_CMP,
    S_EMIT_RD,
    S_EMIT
  } step_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_FETCH,
    OP_GETV,
    OP_CMP,
    OP_EMIT_RD,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_LAST,
    C_SCAN_DONE,
    C_POP,
    C_FINAL
  } cond_t;

  typedef struct packed {
    op_t   op;
    logic  in_ready;
    logic  hold_out;
    cond_t cond;
    step_t jump;
    step_t seq;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '{op: OP_LOAD, in_ready: 1'b1, hold_out: 1'b0, cond: C_LAST,
          jump: S_FETCH, seq: S_LOAD};
    unique case (s)
      S_LOAD:    w = '{op: OP_LOAD, in_ready: 1'b1, hold_out: 1'b0, cond: C_LAST,
                       jump: S_FETCH, seq: S_LOAD};
      S_FETCH:   w = '{op: OP_FETCH, in_ready: 1'b0, hold_out: 1'b0,
                       cond: C_SCAN_DONE, jump: S_EMIT_RD, seq: S_GETV};
      S_GETV:    w = '{op: OP_GETV, in_ready: 1'b0, hold_out: 1'b0, cond: C_NONE,
                       jump: S_CMP, seq: S_CMP};
      S_CMP:     w = '{op: OP_CMP, in_ready: 1'b0, hold_out: 1'b0, cond: C_POP,
                       jump: S_CMP, seq: S_FETCH};
      S_EMIT_RD: w = '{op: OP_EMIT_RD, in_ready: 1'b0, hold_out: 1'b0,
                       cond: C_NONE, jump: S_EMIT, seq: S_EMIT};
      S_EMIT:    w = '{op: OP_EMIT, in_ready: 1'b0, hold_out: 1'b1, cond: C_FINAL,
                       jump: S_LOAD, seq: S_EMIT_RD};
      default:   w = '{op: OP_LOAD, in_ready: 1'b1, hold_out: 1'b0, cond: C_LAST,
                       jump: S_FETCH, seq: S_LOAD};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/next_greater_index.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// next_greater_index
// Next-greater-element finder over a loaded sequence, monotonic index stack.
//
// Input channel in_valid/in_ready/in_item: one signed value per item, the last
// item of a sequence flagged by last_in. Items are taken one per cycle while
// loading; beyond 64 stored items further items are dropped and the run is
// marked overflowed.
// After the flagged item the block scans the sequence backwards (fetch, value
// read and compare for each element, the compare repeated for every stack pop)
// and takes no input meanwhile.
// Output channel out_valid/out_ready/out_item: one result per stored element,
// in index order, each read from the answer memory and then registered, the
// final one flagged by last_out. A stalled receiver holds the output register
// and the sequencer waits on it. The next sequence may start loading while the
// final result still waits.
// Reset (synchronous, rst_n low) empties the block and returns it to loading.
// ----------------------------------------------------------------------------
module next_greater_index (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  ngi_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output ngi_pkg::out_item_t  out_item
);

  logic [ngi_pkg::KEY_W-1:0]   vmem [ngi_pkg::MAX_ITEMS];
  ngi_pkg::stack_entry_t       smem [ngi_pkg::MAX_ITEMS];
  ngi_pkg::answer_t            amem [ngi_pkg::MAX_ITEMS];

  ngi_pkg::step_t              step_r, step_nxt;
  ngi_pkg::ucode_t             uc;

  logic [ngi_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ngi_pkg::CNT_W-1:0]   k_r, k_nxt;
  logic [ngi_pkg::CNT_W-1:0]   sp_r, sp_nxt;
  logic [ngi_pkg::CNT_W-1:0]   pos_r, pos_nxt;
  logic [ngi_pkg::IDX_W-1:0]   i_r, i_nxt;
  logic [ngi_pkg::KEY_W-1:0]   vi_r, vi_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        out_valid_r, out_valid_nxt;
  ngi_pkg::out_item_t          out_item_r;

  logic                        vmem_we;
  logic [ngi_pkg::IDX_W-1:0]   vmem_wa, vmem_ra;
  logic [ngi_pkg::KEY_W-1:0]   vmem_wd, vmem_rd_r;
  logic                        smem_we;
  logic [ngi_pkg::IDX_W-1:0]   smem_wa, smem_ra;
  ngi_pkg::stack_entry_t       smem_wd, smem_rd_r;
  logic                        amem_we;
  logic [ngi_pkg::IDX_W-1:0]   amem_wa, amem_ra;
  ngi_pkg::answer_t            amem_wd, amem_rd_r;

  logic                        in_acc;
  logic [ngi_pkg::KEY_W-1:0]   in_key;
  logic [ngi_pkg::CNT_W-1:0]   k_m1, sp_m1, sp_m2, pos_inc, cnt_load;
  logic                        pop, emit_free, final_res, out_load;
  logic                        cond_hit, hold_hit;

  assign uc        = ngi_pkg::ucode_rom(step_r);
  assign in_ready  = uc.in_ready;
  assign in_acc    = in_valid && in_ready;
  assign in_key    = {~in_item.value[ngi_pkg::VALUE_BITS-1],
                      in_item.value[ngi_pkg::VALUE_BITS-2:0]};
  assign k_m1      = k_r - ngi_pkg::CNT_ONE;
  assign sp_m1     = sp_r - ngi_pkg::CNT_ONE;
  assign sp_m2     = sp_r - ngi_pkg::CNT_TWO;
  assign pos_inc   = pos_r + ngi_pkg::CNT_ONE;
  assign pop       = (sp_r != '0) && (smem_rd_r.key <= vi_r);
  assign emit_free = !out_valid_r || out_ready;
  assign final_res = (pos_inc == cnt_r);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    k_nxt    = k_r;
    sp_nxt   = sp_r;
    pos_nxt  = pos_r;
    i_nxt    = i_r;
    vi_nxt   = vi_r;
    ovf_nxt  = ovf_r;
    out_load = 1'b0;
    cnt_load = cnt_r;
    vmem_we  = 1'b0;
    vmem_wa  = cnt_r[ngi_pkg::IDX_W-1:0];
    vmem_wd  = in_key;
    vmem_ra  = k_m1[ngi_pkg::IDX_W-1:0];
    smem_we  = 1'b0;
    smem_wa  = sp_r[ngi_pkg::IDX_W-1:0];
    smem_wd  = '{key: vi_r, idx: i_r};
    smem_ra  = sp_m1[ngi_pkg::IDX_W-1:0];
    amem_we  = 1'b0;
    amem_wa  = i_r;
    amem_wd  = '{found: (sp_r != '0),
                 idx: (sp_r != '0) ? smem_rd_r.idx : '0};
    amem_ra  = pos_r[ngi_pkg::IDX_W-1:0];
    unique case (uc.op)
      ngi_pkg::OP_LOAD: begin
        if (in_acc) begin
          if (cnt_r < ngi_pkg::CNT_MAX) begin
            vmem_we  = 1'b1;
            cnt_load = cnt_r + ngi_pkg::CNT_ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
          cnt_nxt = cnt_load;
          if (in_item.last_in) begin
            k_nxt   = cnt_load;
            sp_nxt  = '0;
            pos_nxt = '0;
          end
        end
      end
      ngi_pkg::OP_FETCH: begin
        if (k_r != '0) begin
          i_nxt = k_m1[ngi_pkg::IDX_W-1:0];
          k_nxt = k_m1;
        end
      end
      ngi_pkg::OP_GETV: begin
        vi_nxt = vmem_rd_r;
      end
      ngi_pkg::OP_CMP: begin
        if (pop) begin
          sp_nxt  = sp_m1;
          smem_ra = sp_m2[ngi_pkg::IDX_W-1:0];
        end else begin
          amem_we = 1'b1;
          if (sp_r < ngi_pkg::CNT_MAX) begin
            smem_we = 1'b1;
            sp_nxt  = sp_r + ngi_pkg::CNT_ONE;
          end
        end
      end
      ngi_pkg::OP_EMIT_RD: begin
        amem_ra = pos_r[ngi_pkg::IDX_W-1:0];
      end
      ngi_pkg::OP_EMIT: begin
        if (emit_free) begin
          out_load = 1'b1;
          pos_nxt  = pos_inc;
          if (final_res) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
          end
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_comb begin
    unique case (uc.cond)
      ngi_pkg::C_NONE:      cond_hit = 1'b0;
      ngi_pkg::C_LAST:      cond_hit = in_acc && in_item.last_in;
      ngi_pkg::C_SCAN_DONE: cond_hit = (k_r == '0);
      ngi_pkg::C_POP:       cond_hit = pop;
      ngi_pkg::C_FINAL:     cond_hit = final_res;
      default:              cond_hit = 1'b0;
    endcase
    hold_hit = uc.hold_out && !emit_free;
    if (hold_hit) begin
      step_nxt = step_r;
    end else if (cond_hit) begin
      step_nxt = uc.jump;
    end else begin
      step_nxt = uc.seq;
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ngi_pkg::S_LOAD;
      cnt_r       <= '0;
      k_r         <= '0;
      sp_r        <= '0;
      pos_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      sp_r        <= sp_nxt;
      pos_r       <= pos_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r  <= i_nxt;
    vi_r <= vi_nxt;
    if (out_load) begin
      out_item_r <= '{position:    pos_r[ngi_pkg::IDX_W-1:0],
                      next_index:  amem_rd_r.idx,
                      has_greater: amem_rd_r.found,
                      overflowed:  ovf_r,
                      last_out:    final_res};
    end
  end

  always_ff @(posedge clk) begin
    if (vmem_we) begin
      vmem[vmem_wa] <= vmem_wd;
    end
    vmem_rd_r <= vmem[vmem_ra];
  end

  always_ff @(posedge clk) begin
    if (smem_we) begin
      smem[smem_wa] <= smem_wd;
    end
    smem_rd_r <= smem[smem_ra];
  end

  always_ff @(posedge clk) begin
    if (amem_we) begin
      amem[amem_wa] <= amem_wd;
    end
    amem_rd_r <= amem[amem_ra];
  end

`ifndef NO_ASSERTIONS
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= ngi_pkg::CNT_MAX)
    else $error("stack depth beyond capacity");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ngi_pkg::CNT_MAX)
    else $error("item count beyond capacity");

  a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ngi_pkg::S_FETCH || step_r == ngi_pkg::S_GETV ||
     step_r == ngi_pkg::S_CMP) |-> (k_r < cnt_r || k_r == cnt_r))
    else $error("scan pointer beyond stored items");

  a_emit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ngi_pkg::S_EMIT_RD || step_r == ngi_pkg::S_EMIT) |-> pos_r < cnt_r)
    else $error("result position beyond stored items");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ngi_pkg::S_EMIT && out_load && final_res)
      |=> (cnt_r == '0 && out_valid && out_item.last_out))
    else $error("run did not close after final result");
`endif

endmodule
`default_nettype wire

// ===== verif/next_greater_index_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_greater_index_tb
// Loads signed sequences into the block and checks every answer it returns.
// Accepted items go into a local copy of the sequence, up to 64 per run; the
// rest only mark it dropped. A marked item starts a backward monotonic-stack
// scan that queues the expected answers. Answers are compared field by field,
// in order. Both sides idle at random.
module next_greater_index_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int RANDOM_ITEMS   = 200;

  class answer_board;
    logic signed [31:0] seq_vals [ngi_pkg::MAX_ITEMS];
    int unsigned        n_stored;
    bit                 dropped;
    ngi_pkg::out_item_t awaited_answers [$];
    int unsigned        errors;

    function new();
      n_stored = 0;
      dropped  = 1'b0;
      errors   = 0;
    endfunction

    function void note_item(ngi_pkg::in_item_t it);
      if (n_stored < ngi_pkg::MAX_ITEMS) begin
        seq_vals[n_stored] = it.value;
        n_stored++;
      end else begin
        dropped = 1'b1;
      end
      if (it.last_in) begin
        predict_answers();
      end
    endfunction

    function void predict_answers();
      int                 pending_idx [$];
      bit                 found [ngi_pkg::MAX_ITEMS];
      int                 nearest [ngi_pkg::MAX_ITEMS];
      ngi_pkg::out_item_t r;
      for (int i = int'(n_stored) - 1; i >= 0; i--) begin
        while (pending_idx.size() > 0 && seq_vals[pending_idx[$]] <= seq_vals[i]) begin
          void'(pending_idx.pop_back());
        end
        found[i]   = pending_idx.size() > 0;
        nearest[i] = found[i] ? pending_idx[$] : 0;
        pending_idx.push_back(i);
      end
      for (int i = 0; i < int'(n_stored); i++) begin
        r.position    = i[5:0];
        r.next_index  = nearest[i][5:0];
        r.has_greater = found[i];
        r.overflowed  = dropped;
        r.last_out    = (i == int'(n_stored) - 1);
        awaited_answers.push_back(r);
      end
      n_stored = 0;
      dropped  = 1'b0;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(ngi_pkg::out_item_t got);
      ngi_pkg::out_item_t want;
      if (awaited_answers.size() == 0) begin
        $error("unexpected answer: position %0d", got.position);
        errors++;
        return;
      end
      want = awaited_answers.pop_front();
      compare_field("position", want.position, got.position);
      compare_field("next_index", want.next_index, got.next_index);
      compare_field("has_greater", want.has_greater, got.has_greater);
      compare_field("overflowed", want.overflowed, got.overflowed);
      compare_field("last_out", want.last_out, got.last_out);
    endfunction

    function int pending();
      return awaited_answers.size();
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  ngi_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ngi_pkg::out_item_t out_item;

  answer_board board = new();
  bit          calm  = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned random_sent  = 0;

  logic signed [31:0] dir_vals [0:22] = '{
    32'sh8000_0000,
    32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000, -32'sd1, 32'sh7fff_ffff,
    32'sd7, 32'sd7, 32'sd7, 32'sd7,
    32'sd1, 32'sd2, 32'sd3, 32'sd4,
    32'sd4, 32'sd3, 32'sd2, 32'sd1,
    -32'sd5, 32'sd3, -32'sd2, 32'sd8, 32'sd0
  };
  bit dir_last [0:22] = '{
    1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1
  };

  next_greater_index i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 17);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_item);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** next_greater_index: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 8)) - 32'sd4;
      1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom);
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic signed [31:0] v, input bit last);
    ngi_pkg::in_item_t it;
    it.value   = v;
    it.last_in = last;
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    board.note_item(it);
    @(negedge clk);
  endtask

  task automatic send_random_run(input int len);
    for (int k = 0; k < len; k++) begin
      send_item(pick_value(), k == len - 1);
      random_sent++;
    end
  endtask

  initial begin
    int run_no;
    int len;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k <= 22; k++) begin
      send_item(dir_vals[k], dir_last[k]);
    end

    // full buffer, then a run whose marked item is dropped
    send_random_run(ngi_pkg::MAX_ITEMS);
    send_random_run(ngi_pkg::MAX_ITEMS + 3);

    run_no = 0;
    while (random_sent < RANDOM_ITEMS) begin
      calm = (run_no >= 3 && run_no <= 9);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
      send_random_run(len);
      run_no++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending() != 0) begin
      $error("%0d answers never arrived", board.pending());
      board.errors++;
    end

    if (board.errors == 0) begin
      $display("** next_greater_index: PASSED **");
    end else begin
      $display("** next_greater_index: FAILED **");
    end
    $finish;
  end

endmodule
